/* src/brb_pkg.sv */
// Shared definitions for the byte ring buffer: command codes, beat types
// and sizing constants. No dependencies.
`default_nettype none

package brb_pkg;

  // Command codes carried in the command field of an input beat.
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_SEEK = 2'd3;

  // Default storage depth and the largest capacity the register can select.
  localparam int DEPTH_DEFAULT = 256;
  localparam int CAP_LIMIT     = 256;

  // Width of the capacity register.
  localparam int CAP_W = 9;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_in;
    logic [7:0] position;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] data_out;
    logic [7:0] level;
    logic       is_empty;
    logic       is_full;
  } out_item_t;

endpackage

`default_nettype wire

/* src/brb_ram.sv */
// Simple dual-port byte storage with one write port and one registered
// read port. Depends on nothing but its parameters.
`default_nettype none

module brb_ram #(
  parameter int ENTRIES = 256,
  parameter int AW      = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/byte_ring_buffer_peek_seek.sv */
// Top level of the byte ring buffer: pointer and level logic around the
// byte storage. Depends on brb_pkg and brb_ram.
//
// The buffer takes one command beat (push, pop, peek or seek) in every clock
// cycle and never raises busy. The result beat of a command appears on the
// out_ ports in the cycle after start, for exactly one cycle, marked by
// out_valid; the receiver must take it then, as it cannot stall the block.
// The result fields are registered; pop and peek read their data through the
// registered read port of the storage. A write of the capacity register empties
// the buffer; values outside 2 to 256 (or above DEPTH) are saturated.
`default_nettype none

module byte_ring_buffer_peek_seek
  import brb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  output out_item_t             out_result,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int CAP_MAX = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam int IW      = $clog2(CAP_MAX);
  localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);

  // Sum of an index and an offset, wrapped once at the capacity.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CAP_W-1:0] add,
                                             input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] s;
    s = (CAP_W+1)'(base) + (CAP_W+1)'(add);
    if (s >= (CAP_W+1)'(cap)) begin
      s = s - (CAP_W+1)'(cap);
    end
    return IW'(s);
  endfunction

  // Number of bytes between the read and the write index.
  function automatic logic [CAP_W-1:0] fill(input logic [IW-1:0] rd,
                                            input logic [IW-1:0] wr,
                                            input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] lv;
    if (wr >= rd) begin
      lv = CAP_W'(wr) - CAP_W'(rd);
    end else begin
      lv = cap - CAP_W'(rd) + CAP_W'(wr);
    end
    return lv;
  endfunction

  logic [CAP_W-1:0] cap_r;
  logic [IW-1:0]    rd_r, wr_r;
  logic [IW-1:0]    rd_nxt, wr_nxt;
  logic [IW-1:0]    rd_cur, wr_cur, wr_inc;
  logic [CAP_W-1:0] lvl_cur, lvl_nxt, cap_sat;
  logic             accept;
  logic             ok;
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;
  logic             out_valid_r, rsel_r, ok_r;
  logic [7:0]       level_r;
  logic             empty_r, full_r;

  // The block never stalls: busy is tied low.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Saturate a written capacity to the supported range.
  always_comb begin
    cap_sat = cfg_wdata;
    if (cap_sat < CAP_W'(2)) begin
      cap_sat = CAP_W'(2);
    end
    if (cap_sat > CAP_MAX_V) begin
      cap_sat = CAP_MAX_V;
    end
  end

  // Indices as seen by the current command.
  assign rd_cur  = (CAP_W'(rd_r) >= cap_r) ? '0 : rd_r;
  assign wr_cur  = (CAP_W'(wr_r) >= cap_r) ? '0 : wr_r;
  assign wr_inc  = wrap_add(wr_cur, CAP_W'(1), cap_r);
  assign lvl_cur = fill(rd_cur, wr_cur, cap_r);

  // Command decode: index updates and storage accesses.
  always_comb begin
    rd_nxt    = rd_cur;
    wr_nxt    = wr_cur;
    ok        = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rd_cur;
    unique case (in_item.command)
      CMD_PUSH: begin
        if (wr_inc != rd_cur) begin
          mem_we = accept;
          wr_nxt = wr_inc;
          ok     = 1'b1;
        end
      end
      CMD_POP: begin
        if (rd_cur != wr_cur) begin
          mem_re = accept;
          rd_nxt = wrap_add(rd_cur, CAP_W'(1), cap_r);
          ok     = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (CAP_W'(in_item.position) < lvl_cur) begin
          mem_re    = accept;
          mem_raddr = wrap_add(rd_cur, CAP_W'(in_item.position), cap_r);
          ok        = 1'b1;
        end
      end
      CMD_SEEK: begin
        if (CAP_W'(in_item.position) <= lvl_cur) begin
          rd_nxt = wrap_add(rd_cur, CAP_W'(in_item.position), cap_r);
          ok     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign lvl_nxt = fill(rd_nxt, wr_nxt, cap_r);

  // Control registers: capacity and indices; a capacity write empties the buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_MAX_V;
      rd_r        <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (cfg_we) begin
        cap_r <= cap_sat;
        rd_r  <= '0;
        wr_r  <= '0;
      end else if (accept) begin
        rd_r <= rd_nxt;
        wr_r <= wr_nxt;
      end
    end
  end

  // Result beat fields, captured with the command.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r    <= ok;
      rsel_r  <= ok && (in_item.command == CMD_POP || in_item.command == CMD_PEEK);
      level_r <= 8'(lvl_nxt);
      empty_r <= (rd_nxt == wr_nxt);
      full_r  <= (wrap_add(wr_nxt, CAP_W'(1), cap_r) == rd_nxt);
    end
  end

  brb_ram #(
    .ENTRIES(CAP_MAX),
    .AW     (IW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_cur),
    .wdata(in_item.data_in),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Drive the result beat.
  assign out_valid           = out_valid_r;
  assign out_result.accepted = ok_r;
  assign out_result.data_out = rsel_r ? mem_rdata : 8'd0;
  assign out_result.level    = level_r;
  assign out_result.is_empty = empty_r;
  assign out_result.is_full  = full_r;

  // Checks on the block's own logic.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("command beat produced no result beat");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.is_empty && out_result.is_full))
    else $error("buffer reported empty and full at once");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.is_empty == (out_result.level == 8'd0)))
    else $error("empty flag disagrees with level");

  a_refused_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.accepted) |-> (out_result.data_out == 8'd0))
    else $error("refused command returned data");

endmodule

`default_nettype wire

/* tb/sv/tb_byte_ring_buffer_peek_seek.sv */
// Self-checking testbench for the byte ring buffer with peek and seek.
// Depends on brb_pkg and byte_ring_buffer_peek_seek; holds its own ring model.
`default_nettype none

module tb_byte_ring_buffer_peek_seek;
  import brb_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // One row of the directed table: a command beat or a capacity write.
  typedef struct {
    row_kind_t        kind;
    in_item_t         item;
    logic [CAP_W-1:0] cap_value;
    bit               pinned;
    out_item_t        value;
  } dir_row_t;

  // Expectation typed into the table, handed from the driver to the monitor.
  typedef struct {
    bit        pinned;
    out_item_t value;
  } pinned_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_valid;
  out_item_t        out_result;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  // Ring model state.
  logic [7:0]       ring_mem [DEPTH_DEFAULT];
  int               ring_rd;
  int               ring_wr;
  logic [CAP_W-1:0] ring_cap_reg;

  out_item_t result_q [$];
  pinned_t   pinned_q [$];
  int        mismatches;
  int        quiet_cycles;
  dir_row_t  dir_rows [$];

  byte_ring_buffer_peek_seek u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Capacity in use: the register saturated to the legal range and the depth.
  function automatic int ring_cap();
    int c;
    c = ring_cap_reg;
    if (c < 2) c = 2;
    if (c > CAP_LIMIT) c = CAP_LIMIT;
    if (c > DEPTH_DEFAULT) c = DEPTH_DEFAULT;
    return c;
  endfunction

  function automatic int ring_wrap(int base, int add, int cap);
    int s;
    s = base + add;
    if (s >= cap) s -= cap;
    return s;
  endfunction

  function automatic int ring_fill(int cap);
    if (ring_wr >= ring_rd) return ring_wr - ring_rd;
    return (cap - ring_rd) + ring_wr;
  endfunction

  // Applies one command to the ring model and returns the result beat it yields.
  function automatic out_item_t ring_step(in_item_t it);
    int        cap;
    int        lvl;
    out_item_t r;
    cap = ring_cap();
    if (ring_rd >= cap) ring_rd = 0;
    if (ring_wr >= cap) ring_wr = 0;
    lvl = ring_fill(cap);
    r = '0;
    case (it.command)
      CMD_PUSH: begin
        if (ring_wrap(ring_wr, 1, cap) != ring_rd) begin
          ring_mem[ring_wr] = it.data_in;
          ring_wr = ring_wrap(ring_wr, 1, cap);
          r.accepted = 1'b1;
        end
      end
      CMD_POP: begin
        if (ring_rd != ring_wr) begin
          r.data_out = ring_mem[ring_rd];
          ring_rd = ring_wrap(ring_rd, 1, cap);
          r.accepted = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (int'(it.position) < lvl) begin
          r.data_out = ring_mem[ring_wrap(ring_rd, int'(it.position), cap)];
          r.accepted = 1'b1;
        end
      end
      CMD_SEEK: begin
        if (int'(it.position) <= lvl) begin
          ring_rd = ring_wrap(ring_rd, int'(it.position), cap);
          r.accepted = 1'b1;
        end
      end
    endcase
    r.level    = 8'(ring_fill(cap));
    r.is_empty = (ring_rd == ring_wr);
    r.is_full  = (ring_wrap(ring_wr, 1, cap) == ring_rd);
    return r;
  endfunction

  function automatic out_item_t res(bit acc, logic [7:0] dout, logic [7:0] lvl,
                                    bit emp, bit full);
    out_item_t r;
    r.accepted = acc;
    r.data_out = dout;
    r.level    = lvl;
    r.is_empty = emp;
    r.is_full  = full;
    return r;
  endfunction

  function automatic dir_row_t cmd_row(logic [1:0] cmd, logic [7:0] data, logic [7:0] pos,
                                       bit pinned = 1'b0, out_item_t value = '0);
    dir_row_t r;
    r.kind          = ROW_CMD;
    r.item.command  = cmd;
    r.item.data_in  = data;
    r.item.position = pos;
    r.cap_value     = '0;
    r.pinned        = pinned;
    r.value         = value;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CAP_W-1:0] v);
    dir_row_t r;
    r.kind      = ROW_CFG;
    r.item      = '0;
    r.cap_value = v;
    r.pinned    = 1'b0;
    r.value     = '0;
    return r;
  endfunction

  // Monitor: checks result beats, tracks capacity writes and predicts accepted beats.
  always @(posedge clk) begin
    out_item_t e;
    out_item_t pred;
    pinned_t   pin;
    if (!rst_n) begin
      ring_cap_reg = CAP_W'(CAP_LIMIT);
      ring_rd      = 0;
      ring_wr      = 0;
      quiet_cycles = 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: acc=%0d dout=%h lvl=%0d empty=%0d full=%0d",
                     out_result.accepted, out_result.data_out, out_result.level,
                     out_result.is_empty, out_result.is_full);
        end else begin
          e = result_q.pop_front();
          if (out_result.accepted !== e.accepted || out_result.data_out !== e.data_out ||
              out_result.level !== e.level || out_result.is_empty !== e.is_empty ||
              out_result.is_full !== e.is_full) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected acc=%0d dout=%h lvl=%0d empty=%0d full=%0d,",
                       e.accepted, e.data_out, e.level, e.is_empty, e.is_full,
                       " got acc=%0d dout=%h lvl=%0d empty=%0d full=%0d",
                       out_result.accepted, out_result.data_out, out_result.level,
                       out_result.is_empty, out_result.is_full);
          end
        end
      end
      // A capacity write empties the ring.
      if (cfg_we) begin
        ring_cap_reg = cfg_wdata;
        ring_rd      = 0;
        ring_wr      = 0;
      end
      if (start && !busy) begin
        pred = ring_step(in_item);
        pin  = '{pinned: 1'b0, value: '0};
        if (pinned_q.size() != 0) pin = pinned_q.pop_front();
        result_q.push_back(pin.pinned ? pin.value : pred);
      end
      if ((start && !busy) || out_valid || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Watchdog on cycles with no beat of any kind.
  initial begin
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Presents one command beat and holds it until the block takes it.
  task automatic send_beat(in_item_t it, bit pinned = 1'b0, out_item_t value = '0);
    start   <= 1'b1;
    in_item <= it;
    pinned_q.push_back('{pinned: pinned, value: value});
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits for the outstanding results to drain, then writes the capacity register.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    start <= 1'b0;
    while (result_q.size() != 0 || pinned_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random commands at one capacity; a high push share drives the ring to full.
  task automatic run_phase(logic [CAP_W-1:0] cap_value, int n, int push_pct, int idle_pct);
    in_item_t it;
    int       lvl;
    int       hi;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct) it.command = CMD_PUSH;
      else it.command = 2'($urandom_range(1, 3));
      it.data_in = 8'($urandom_range(0, 255));
      lvl = ring_fill(ring_cap());
      hi  = (lvl + 1 > 255) ? 255 : lvl + 1;
      if (push_pct >= 90) it.position = 8'($urandom_range(0, 2));
      else if ($urandom_range(0, 9) < 2) it.position = 8'($urandom_range(0, 255));
      else it.position = 8'($urandom_range(0, hi));
      if (i == 0) write_capacity(cap_value);
      send_beat(it);
      if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 9));
    end
  endtask

  // Stimulus: directed table, random phases, then drain and verdict.
  initial begin
    int wait_cycles;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;

    // Empty ring after reset, then a short fill and drain.
    dir_rows.push_back(cmd_row(CMD_POP,  8'h00, 8'd0,   1'b1, res(0, 8'h00, 8'd0, 1, 0)));
    dir_rows.push_back(cmd_row(CMD_PEEK, 8'h00, 8'd0,   1'b1, res(0, 8'h00, 8'd0, 1, 0)));
    dir_rows.push_back(cmd_row(CMD_SEEK, 8'h00, 8'd0,   1'b1, res(1, 8'h00, 8'd0, 1, 0)));
    dir_rows.push_back(cmd_row(CMD_SEEK, 8'h00, 8'd255, 1'b1, res(0, 8'h00, 8'd0, 1, 0)));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'hFF, 8'd0,   1'b1, res(1, 8'h00, 8'd1, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'h00, 8'd255, 1'b1, res(1, 8'h00, 8'd2, 0, 0)));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'hA5, 8'd0));
    dir_rows.push_back(cmd_row(CMD_PEEK, 8'h00, 8'd2));
    dir_rows.push_back(cmd_row(CMD_PEEK, 8'h00, 8'd3));
    dir_rows.push_back(cmd_row(CMD_PEEK, 8'hFF, 8'd255));
    dir_rows.push_back(cmd_row(CMD_POP,  8'h00, 8'd0));
    dir_rows.push_back(cmd_row(CMD_SEEK, 8'h00, 8'd3));
    dir_rows.push_back(cmd_row(CMD_SEEK, 8'h00, 8'd2));
    // Smallest capacity: one byte makes the ring full.
    dir_rows.push_back(cfg_row(9'd2));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'h5A, 8'd0,   1'b1, res(1, 8'h00, 8'd1, 0, 1)));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'h3C, 8'd0,   1'b1, res(0, 8'h00, 8'd1, 0, 1)));
    dir_rows.push_back(cmd_row(CMD_PEEK, 8'h00, 8'd0));
    dir_rows.push_back(cmd_row(CMD_POP,  8'h00, 8'd0));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'hC3, 8'd0));
    dir_rows.push_back(cmd_row(CMD_POP,  8'h00, 8'd0));
    // Register values outside the legal range saturate.
    dir_rows.push_back(cfg_row(9'd511));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'h81, 8'd0));
    dir_rows.push_back(cmd_row(CMD_PEEK, 8'h00, 8'd0));
    dir_rows.push_back(cfg_row(9'd0));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'h7E, 8'd0));
    dir_rows.push_back(cmd_row(CMD_PUSH, 8'h11, 8'd0));
    dir_rows.push_back(cmd_row(CMD_SEEK, 8'h00, 8'd1));
    dir_rows.push_back(cmd_row(CMD_POP,  8'h00, 8'd0,   1'b1, res(0, 8'h00, 8'd0, 1, 0)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_capacity(dir_rows[i].cap_value);
      else send_beat(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].value);
    end

    run_phase(9'd2,   40, 50, 25);
    run_phase(9'd3,   40, 55, 0);
    run_phase(9'd0,   30, 50, 25);
    run_phase(9'd1,   30, 50, 30);
    run_phase(9'd257, 30, 45, 25);
    run_phase(9'd511, 30, 50, 25);
    run_phase(9'd256, 300, 95, 20);
    run_phase(9'($urandom_range(2, 16)),  50, 55, 25);
    run_phase(9'($urandom_range(0, 511)), 50, 50, 25);
    run_phase(9'd4,   40, 50, 0);

    // Drain the outstanding results, then allow for the block's latency.
    start <= 1'b0;
    wait_cycles = 0;
    while (result_q.size() != 0 && wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);
    mismatches += result_q.size();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
